// ----- sv/tfcd_pkg.sv -----
`timescale 1ns / 1ps

package tfcd_pkg;

   localparam int unsigned FrameLen  = 26;
   localparam int unsigned CheckPos  = 25;
   localparam int unsigned FirstKept = 2;
   localparam int unsigned LastKept  = 20;

   localparam logic [7:0] ServiceType = 8'h03;
   localparam logic [7:0] EndMark     = 8'd65;

   localparam logic [1:0] StatusMeasure = 2'd0;
   localparam logic [1:0] StatusBroken  = 2'd1;
   localparam logic [1:0] StatusStart   = 2'd2;
   localparam logic [1:0] StatusEnd     = 2'd3;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         pointing_number;
      logic [7:0]         info_type;
      logic               time_ref;
      logic [16:0]        time_seconds;
      logic [9:0]         time_millis;
      logic signed [15:0] azimuth;
      logic signed [15:0] elevation;
      logic [22:0]        distance;
      logic [31:0]        good_count;
      logic [31:0]        broken_count;
   } result_type;

   // Eight-bit sum with the carry folded back into bit 0.
   function automatic logic [7:0] sum_add(input logic [7:0] acc, input logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, acc} + {1'b0, b};
      return t[7:0] + {7'd0, t[8]};
   endfunction

   function automatic logic [9:0] millis_of(input logic [1:0] code);
      logic [9:0] ms;
      case (code)
         2'd0:    ms = 10'd0;
         2'd1:    ms = 10'd250;
         2'd2:    ms = 10'd500;
         2'd3:    ms = 10'd750;
         default: ms = 10'd0;
      endcase
      return ms;
   endfunction

endpackage

// ----- sv/telemetry_frame_checker_decoder_top.sv -----
`timescale 1ns / 1ps
// The result word is registered and appears in the cycle after the checksum byte is accepted.
// Throughput: one input word per cycle while req_ready is high; the running sum and field capture are registered.
// The output register holds a result until taken, and new words are accepted meanwhile
// whenever that register is empty or being emptied in the same cycle.
// Reset clears the byte position, running sum, both frame counts and the output valid.
module telemetry_frame_checker_decoder_top import tfcd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_first_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_pointing_number,
   output logic [7:0]         rsp_info_type,
   output logic               rsp_time_ref,
   output logic [16:0]        rsp_time_seconds,
   output logic [9:0]         rsp_time_millis,
   output logic signed [15:0] rsp_azimuth,
   output logic signed [15:0] rsp_elevation,
   output logic [22:0]        rsp_distance,
   output logic [31:0]        rsp_good_count,
   output logic [31:0]        rsp_broken_count
);

   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] broken_ff, broken_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   byte_type    frame_ff [FirstKept:LastKept];

   logic        accept;
   logic        frame_we;
   logic        done;
   result_type  decoded;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   tfcd_decode u_decode (
      .frame         (frame_ff),
      .check_byte    (req_data_byte),
      .running_sum   (sum_ff),
      .good_frames   (good_ff),
      .broken_frames (broken_ff),
      .result        (decoded)
   );

   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      good_in   = good_ff;
      broken_in = broken_ff;
      frame_we  = 1'b0;
      done      = 1'b0;
      if (accept) begin
         if (req_first_byte) begin
            sum_in = req_data_byte;
            pos_in = 5'd1;
         end else if (pos_ff == 5'd0 || pos_ff >= 5'(FrameLen)) begin
            pos_in = 5'd0;
         end else if (pos_ff < 5'(CheckPos)) begin
            frame_we = 1'b1;
            sum_in   = sum_add(sum_ff, req_data_byte);
            pos_in   = pos_ff + 5'd1;
         end else begin
            done      = 1'b1;
            pos_in    = 5'd0;
            sum_in    = 8'd0;
            good_in   = decoded.good_count;
            broken_in = decoded.broken_count;
         end
      end
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sum_ff       <= '0;
         good_ff      <= '0;
         broken_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         good_ff      <= good_in;
         broken_ff    <= broken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= decoded;
      end
      for (int i = FirstKept; i <= LastKept; i++) begin
         if (frame_we && pos_ff == 5'(i)) begin
            frame_ff[i] <= req_data_byte;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_pointing_number = rsp_ff.pointing_number;
   assign rsp_info_type       = rsp_ff.info_type;
   assign rsp_time_ref        = rsp_ff.time_ref;
   assign rsp_time_seconds    = rsp_ff.time_seconds;
   assign rsp_time_millis     = rsp_ff.time_millis;
   assign rsp_azimuth         = rsp_ff.azimuth;
   assign rsp_elevation       = rsp_ff.elevation;
   assign rsp_distance        = rsp_ff.distance;
   assign rsp_good_count      = rsp_ff.good_count;
   assign rsp_broken_count    = rsp_ff.broken_count;

endmodule

// ----- sv/tfcd_decode.sv -----
`timescale 1ns / 1ps

module tfcd_decode import tfcd_pkg::*; (
   input  byte_type    frame [FirstKept:LastKept],
   input  logic [7:0]  check_byte,
   input  logic [7:0]  running_sum,
   input  logic [31:0] good_frames,
   input  logic [31:0] broken_frames,
   output result_type  result
);

   function automatic logic signed [15:0] angle_of(input byte_type b0, input byte_type b1,
                                                   input byte_type b2);
      logic [15:0] mag;
      mag = {1'b0, b0[2:0], b1[6:0], b2[6:2]};
      if (b0[6]) begin
         mag = 16'd0 - mag;
      end
      return signed'(mag);
   endfunction

   logic is_service;
   logic is_end;

   assign is_service = (frame[3] == ServiceType);
   assign is_end     = (frame[5] == EndMark) && (frame[6] == EndMark) && (frame[7] == EndMark);

   always_comb begin
      result = '0;
      result.good_count   = good_frames;
      result.broken_count = broken_frames;
      if (check_byte != running_sum) begin
         result.status       = StatusBroken;
         result.broken_count = broken_frames + 32'd1;
      end else if (is_service) begin
         result.status = is_end ? StatusEnd : StatusStart;
      end else begin
         result.status          = StatusMeasure;
         result.good_count      = good_frames + 32'd1;
         result.pointing_number = frame[2];
         result.info_type       = frame[3];
         result.time_ref        = frame[8][6];
         result.time_seconds    = {frame[8][4:0], frame[9][6:0], frame[10][6:2]};
         result.time_millis     = millis_of(frame[10][1:0]);
         result.azimuth         = angle_of(frame[11], frame[12], frame[13]);
         result.elevation       = angle_of(frame[18], frame[19], frame[20]);
         result.distance        = {frame[14][1:0], frame[15][6:0], frame[16][6:0],
                                   frame[17][6:0]};
      end
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import tfcd_pkg::*;

   typedef logic [FrameLen-1:0][7:0] frame_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_data_byte;
   logic               req_first_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_pointing_number;
   logic [7:0]         rsp_info_type;
   logic               rsp_time_ref;
   logic [16:0]        rsp_time_seconds;
   logic [9:0]         rsp_time_millis;
   logic signed [15:0] rsp_azimuth;
   logic signed [15:0] rsp_elevation;
   logic [22:0]        rsp_distance;
   logic [31:0]        rsp_good_count;
   logic [31:0]        rsp_broken_count;

   telemetry_frame_checker_decoder_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_first_byte      (req_first_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_pointing_number (rsp_pointing_number),
      .rsp_info_type       (rsp_info_type),
      .rsp_time_ref        (rsp_time_ref),
      .rsp_time_seconds    (rsp_time_seconds),
      .rsp_time_millis     (rsp_time_millis),
      .rsp_azimuth         (rsp_azimuth),
      .rsp_elevation       (rsp_elevation),
      .rsp_distance        (rsp_distance),
      .rsp_good_count      (rsp_good_count),
      .rsp_broken_count    (rsp_broken_count)
   );

   // Decoder state mirrored by the testbench.
   byte_type    run_sum;
   int unsigned byte_pos;
   byte_type    frame_buf [FrameLen];
   logic [31:0] good_total;
   logic [31:0] broken_total;

   result_type  pending_results [$];
   int          failures;
   int          frame_words_sent;
   int          frames_sent;
   int          results_seen;
   int          measure_seen;
   int          broken_seen;
   int          service_seen;
   bit          no_idle;
   int          hold_request;
   int          rsp_stall_left;

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic byte_type carry_add(input byte_type a, input byte_type b);
      logic [8:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t[8]) begin
         t = t + 9'd1;
      end
      return t[7:0];
   endfunction

   function automatic logic signed [15:0] angle_from(input int unsigned p);
      logic [15:0] mag;
      mag = {1'b0, frame_buf[p][2:0], frame_buf[p + 1][6:0], frame_buf[p + 2][6:2]};
      if (frame_buf[p][6]) begin
         mag = 16'd0 - mag;
      end
      return mag;
   endfunction

   function automatic bit decode_byte(input byte_type d, input bit first,
                                      output result_type r);
      r = '0;
      if (first) begin
         frame_buf[0] = d;
         run_sum = carry_add(8'd0, d);
         byte_pos = 1;
         return 1'b0;
      end
      if (byte_pos == 0 || byte_pos >= FrameLen) begin
         byte_pos = 0;
         return 1'b0;
      end
      frame_buf[byte_pos] = d;
      if (byte_pos < CheckPos) begin
         run_sum = carry_add(run_sum, d);
         byte_pos = byte_pos + 1;
         return 1'b0;
      end
      byte_pos = 0;
      if (d != run_sum) begin
         broken_total = broken_total + 1;
         r.status = StatusBroken;
      end else if (frame_buf[3] == ServiceType) begin
         if (frame_buf[5] == EndMark && frame_buf[6] == EndMark && frame_buf[7] == EndMark) begin
            r.status = StatusEnd;
         end else begin
            r.status = StatusStart;
         end
      end else begin
         good_total = good_total + 1;
         r.status = StatusMeasure;
         r.pointing_number = frame_buf[2];
         r.info_type = frame_buf[3];
         r.time_ref = frame_buf[8][6];
         r.time_seconds = {frame_buf[8][4:0], frame_buf[9][6:0], frame_buf[10][6:2]};
         r.time_millis = 10'd250 * {8'd0, frame_buf[10][1:0]};
         r.azimuth = angle_from(11);
         r.elevation = angle_from(18);
         r.distance = {frame_buf[14][1:0], frame_buf[15][6:0], frame_buf[16][6:0],
                       frame_buf[17][6:0]};
      end
      run_sum = 8'd0;
      r.good_count = good_total;
      r.broken_count = broken_total;
      return 1'b1;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 96) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic frame_type sealed(input frame_type f);
      byte_type s;
      s = 8'd0;
      for (int i = 0; i < CheckPos; i++) begin
         s = carry_add(s, f[i]);
      end
      f[CheckPos] = s;
      return f;
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      int        pick;
      for (int i = 0; i < FrameLen; i++) begin
         f[i] = 8'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         f[3] = ServiceType;
         f[5] = EndMark;
         f[6] = EndMark;
         f[7] = EndMark;
      end else if (pick < 16) begin
         f[3] = ServiceType;
         if ($urandom_range(0, 1) == 1) begin
            f[5] = EndMark;
            f[6] = EndMark;
         end
      end
      f = sealed(f);
      if ($urandom_range(0, 9) == 0) begin
         f[CheckPos] = f[CheckPos] ^ 8'($urandom_range(1, 255));
      end
      return f;
   endfunction

   task automatic send_word(input byte_type d, input bit first);
      int         gap;
      result_type r;
      gap = no_idle ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_first_byte <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (decode_byte(d, first, r)) begin
         pending_results.push_back(r);
      end
   endtask

   task automatic send_frame(input frame_type f, input int len);
      for (int i = 0; i < len; i++) begin
         send_word(f[i], i == 0);
      end
      frame_words_sent += len;
      frames_sent++;
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no expectation waiting, status %0d", rsp_status);
            failures++;
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            case (want.status)
               StatusMeasure: measure_seen++;
               StatusBroken:  broken_seen++;
               default:       service_seen++;
            endcase
            check_field("status", want.status, rsp_status);
            check_field("pointing_number", want.pointing_number, rsp_pointing_number);
            check_field("info_type", want.info_type, rsp_info_type);
            check_field("time_ref", want.time_ref, rsp_time_ref);
            check_field("time_seconds", want.time_seconds, rsp_time_seconds);
            check_field("time_millis", want.time_millis, rsp_time_millis);
            check_field("azimuth", want.azimuth, rsp_azimuth);
            check_field("elevation", want.elevation, rsp_elevation);
            check_field("distance", want.distance, rsp_distance);
            check_field("good_count", want.good_count, rsp_good_count);
            check_field("broken_count", want.broken_count, rsp_broken_count);
         end
      end
   end

   // The receiver takes a requested hold-off before anything else and
   // otherwise, unless no_idle is set, stalls at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_request > 0) begin
            rsp_stall_left = hold_request;
            hold_request = 0;
         end
         if (rsp_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) begin
               rsp_stall_left = idle_len();
            end
         end
      end
   end

   task automatic test_idle_words();
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h5A, 1'b0);
   endtask

   task automatic test_measurement_fields();
      frame_type f;
      f = '1;
      f[3] = 8'hFE;
      f[18] = 8'hBF;
      send_frame(sealed(f), FrameLen);
      f = '0;
      f[11] = 8'h40;
      f[18] = 8'h40;
      send_frame(sealed(f), FrameLen);
      send_word(8'hA5, 1'b0);
   endtask

   task automatic test_checksum_error();
      frame_type f;
      f = sealed(random_frame());
      f[3] = 8'h10;
      f = sealed(f);
      f[CheckPos] = f[CheckPos] + 8'd1;
      send_frame(f, FrameLen);
      f[3] = ServiceType;
      f = sealed(f);
      f[CheckPos] = ~f[CheckPos];
      send_frame(f, FrameLen);
   endtask

   task automatic test_service_frames();
      frame_type f;
      f = '0;
      f[3] = ServiceType;
      f[5] = EndMark;
      f[6] = EndMark;
      f[7] = EndMark;
      send_frame(sealed(f), FrameLen);
      f[7] = EndMark - 8'd1;
      send_frame(sealed(f), FrameLen);
   endtask

   task automatic test_restart_mid_frame();
      send_frame(random_frame(), 13);
      send_frame(random_frame(), CheckPos);
      send_frame(sealed('1), FrameLen);
   endtask

   task automatic test_output_backpressure();
      frame_type f;
      wait (pending_results.size() == 0);
      hold_request = 300;
      no_idle = 1'b1;
      for (int i = 0; i < 5; i++) begin
         f = random_frame();
         f[3] = 8'h20;
         send_frame(sealed(f), FrameLen);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic();
      int pick;
      while (frame_words_sent < 1300) begin
         no_idle = ($urandom_range(0, 6) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            send_frame(random_frame(), FrameLen);
         end else if (pick < 92) begin
            send_frame(random_frame(), $urandom_range(1, CheckPos));
         end else begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom), 1'($urandom));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'd0;
      req_first_byte = 1'b0;
      rsp_ready = 1'b0;
      run_sum = 8'd0;
      byte_pos = 0;
      good_total = 32'd0;
      broken_total = 32'd0;
      failures = 0;
      frame_words_sent = 0;
      frames_sent = 0;
      results_seen = 0;
      measure_seen = 0;
      broken_seen = 0;
      service_seen = 0;
      no_idle = 1'b0;
      hold_request = 0;
      rsp_stall_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_words();
      test_measurement_fields();
      test_checksum_error();
      test_service_frames();
      test_restart_mid_frame();
      test_output_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (10) @(posedge clock);

      $display("Sent %0d frames (%0d frame words), including partial and restarted ones.",
               frames_sent, frame_words_sent);
      $display("Checked %0d results: %0d measurements, %0d broken, %0d service frames.",
               results_seen, measure_seen, broken_seen, service_seen);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
